@@ design/string_literal_unescape_macros.svh @@
// Assertion shorthands for the string literal unescape checker.
// Each macro samples on the rising edge of clk and is quiet while rst_n is low.
`ifndef STRING_LITERAL_UNESCAPE_MACROS_SVH
`define STRING_LITERAL_UNESCAPE_MACROS_SVH

// Same-cycle implication.
`define SLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("string literal unescape check failed");

// Next-cycle implication.
`define SLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("string literal unescape check failed");

`endif

@@ design/sle_pkg.sv @@
`timescale 1ns / 1ps

package sle_pkg;

  // Most result beats that a single input byte can cause.
  localparam int unsigned NRES_MAX = 6;
  localparam int unsigned CNT_W = $clog2(NRES_MAX + 1);

  localparam int unsigned MAX_ESCAPE_DIGITS_DEF = 8;

  // Result status codes.
  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef logic [CNT_W-1:0] sle_cnt_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_text;
    logic       end_of_text;
  } sle_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_end;
  } sle_out_t;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] status;
  } sle_entry_t;

  // All results of one input byte, oldest in entry 0.
  typedef struct packed {
    sle_cnt_t                    cnt;
    sle_entry_t [NRES_MAX-1:0]   ent;
  } sle_list_t;

endpackage

@@ design/sle_decode.sv @@
`timescale 1ns / 1ps

module sle_decode #(
  parameter int unsigned MAX_ESCAPE_DIGITS = sle_pkg::MAX_ESCAPE_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  sle_pkg::sle_in_t   item,
  output sle_pkg::sle_list_t list
);

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic        raw_mode;
    logic        bytes_mode;
    logic        format_seen;
    logic        quote_is_double;
    logic        escape_active;
    logic [7:0]  escape_letter;
    logic        letter_seen;
    logic [3:0]  digit_count;
    logic [31:0] hex_value;
    logic [31:0] octal_value;
    logic        octal_valid;
    logic [1:0]  continuation_left;
  } dec_state_t;

  typedef struct packed {
    logic               bad;
    sle_pkg::sle_list_t list;
  } emit_t;

  localparam dec_state_t STATE_RESET = '{
    phase:             PH_PREFIX,
    raw_mode:          1'b0,
    bytes_mode:        1'b0,
    format_seen:       1'b0,
    quote_is_double:   1'b0,
    escape_active:     1'b0,
    escape_letter:     8'h00,
    letter_seen:       1'b0,
    digit_count:       4'd0,
    hex_value:         32'd0,
    octal_value:       32'd0,
    octal_valid:       1'b1,
    continuation_left: 2'd0
  };

  localparam logic [3:0] DIGIT_LIMIT = 4'(MAX_ESCAPE_DIGITS);

  localparam logic [31:0] CP_LIMIT = 32'h0011_0000;
  localparam logic [31:0] CP_4BYTE = 32'h0001_0000;
  localparam logic [31:0] CP_3BYTE = 32'h0000_0800;
  localparam logic [31:0] CP_2BYTE = 32'h0000_0080;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_B   = 8'h42;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_UC_N   = 8'h4e;
  localparam logic [7:0] CH_UC_R   = 8'h52;
  localparam logic [7:0] CH_UC_U   = 8'h55;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6e;
  localparam logic [7:0] CH_LC_O   = 8'h6f;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_LC_V   = 8'h76;
  localparam logic [7:0] CH_LC_X   = 8'h78;

  localparam logic [7:0] CC_BEL = 8'h07;
  localparam logic [7:0] CC_BS  = 8'h08;
  localparam logic [7:0] CC_TAB = 8'h09;
  localparam logic [7:0] CC_LF  = 8'h0a;
  localparam logic [7:0] CC_VT  = 8'h0b;
  localparam logic [7:0] CC_FF  = 8'h0c;
  localparam logic [7:0] CC_CR  = 8'h0d;

  function automatic sle_pkg::sle_list_t push(sle_pkg::sle_list_t l, logic [7:0] b,
                                             logic [1:0] st);
    sle_pkg::sle_list_t r;
    r = l;
    if (l.cnt < sle_pkg::sle_cnt_t'(sle_pkg::NRES_MAX)) begin
      r.ent[l.cnt].value  = b;
      r.ent[l.cnt].status = st;
      r.cnt               = l.cnt + sle_pkg::sle_cnt_t'(1);
    end
    return r;
  endfunction

  // Hex digit value, or 16 when the byte is not a hex digit.
  function automatic logic [4:0] hex_digit(logic [7:0] b);
    logic [4:0] d;
    d = 5'd16;
    if (b >= CH_0 && b <= CH_9) begin
      d = {1'b0, 4'(b - CH_0)};
    end else if (b >= CH_LC_A && b <= CH_LC_F) begin
      d = {1'b0, 4'(b - CH_LC_A + 8'd10)};
    end else if (b >= CH_UC_A && b <= CH_UC_F) begin
      d = {1'b0, 4'(b - CH_UC_A + 8'd10)};
    end
    return d;
  endfunction

  // UTF-8 lead byte class: {bad, continuation bytes to follow}.
  function automatic logic [2:0] lead_class(logic [7:0] b);
    logic [2:0] r;
    if (!b[7]) begin
      r = 3'b000;
    end else if (b[7:5] == 3'b110) begin
      r = 3'b001;
    end else if (b[7:4] == 4'b1110) begin
      r = 3'b010;
    end else if (b[7:3] == 5'b11110) begin
      r = 3'b011;
    end else begin
      r = 3'b100;
    end
    return r;
  endfunction

  function automatic emit_t emit_code(sle_pkg::sle_list_t l, logic [31:0] c,
                                      logic bytes_mode);
    emit_t r;
    r.bad  = 1'b0;
    r.list = l;
    if (bytes_mode) begin
      r.list = push(l, c[7:0], sle_pkg::ST_DATA);
    end else if (c >= CP_LIMIT) begin
      r.bad  = 1'b1;
      r.list = push(l, 8'h00, sle_pkg::ST_ERROR);
    end else if (c < CP_2BYTE) begin
      r.list = push(l, c[7:0], sle_pkg::ST_DATA);
    end else if (c < CP_3BYTE) begin
      r.list = push(push(l, {3'b110, c[10:6]}, sle_pkg::ST_DATA),
                    {2'b10, c[5:0]}, sle_pkg::ST_DATA);
    end else if (c < CP_4BYTE) begin
      r.list = push(push(push(l, {4'b1110, c[15:12]}, sle_pkg::ST_DATA),
                         {2'b10, c[11:6]}, sle_pkg::ST_DATA),
                    {2'b10, c[5:0]}, sle_pkg::ST_DATA);
    end else begin
      r.list = push(push(push(push(l, {5'b11110, c[20:18]}, sle_pkg::ST_DATA),
                              {2'b10, c[17:12]}, sle_pkg::ST_DATA),
                         {2'b10, c[11:6]}, sle_pkg::ST_DATA),
                    {2'b10, c[5:0]}, sle_pkg::ST_DATA);
    end
    return r;
  endfunction

  dec_state_t         state_r;
  dec_state_t         state_nxt;
  sle_pkg::sle_list_t res;
  emit_t              em;
  logic [7:0]         b;
  logic [7:0]         quote;
  logic               eot;
  logic               go_on;
  logic               do_copy;
  logic               stop;
  logic               start_run;
  logic [4:0]         d;
  logic [3:0]         limit;
  logic [2:0]         lc;
  logic [31:0]        code;

  always_comb begin
    state_nxt = item.start_of_text ? STATE_RESET : state_r;
    res       = '0;
    em        = '0;
    b         = item.in_byte;
    eot       = item.end_of_text;
    quote     = state_nxt.quote_is_double ? CH_DQUOTE : CH_SQUOTE;
    go_on     = 1'b0;
    do_copy   = 1'b0;
    stop      = 1'b0;
    start_run = 1'b0;
    d         = hex_digit(b);
    limit     = DIGIT_LIMIT;
    lc        = lead_class(b);
    code      = (state_nxt.escape_letter == CH_LC_O) ? state_nxt.octal_value
                                                     : state_nxt.hex_value;

    if (state_nxt.phase == PH_PREFIX) begin
      if (b == CH_SQUOTE || b == CH_DQUOTE) begin
        if (state_nxt.format_seen) begin
          res             = push(res, 8'h00, sle_pkg::ST_ERROR);
          state_nxt.phase = PH_DONE;
        end else begin
          state_nxt.quote_is_double = (b == CH_DQUOTE);
          state_nxt.phase           = PH_BODY;
        end
      end else if (b == CH_LC_R || b == CH_UC_R) begin
        state_nxt.raw_mode = 1'b1;
      end else if (b == CH_LC_B || b == CH_UC_B) begin
        state_nxt.bytes_mode = 1'b1;
      end else if (b == CH_LC_F || b == CH_UC_F) begin
        state_nxt.format_seen = 1'b1;
      end
      if (eot && state_nxt.phase == PH_PREFIX) begin
        res             = push(res, 8'h00, sle_pkg::ST_ERROR);
        state_nxt.phase = PH_DONE;
      end else if (eot && state_nxt.phase == PH_BODY) begin
        res             = push(res, 8'h00, sle_pkg::ST_DONE);
        state_nxt.phase = PH_DONE;
      end
    end else if (state_nxt.phase == PH_BODY) begin
      if (state_nxt.continuation_left != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          res             = push(res, 8'h00, sle_pkg::ST_ERROR);
          state_nxt.phase = PH_DONE;
        end else begin
          res                         = push(res, b, sle_pkg::ST_DATA);
          state_nxt.continuation_left = state_nxt.continuation_left - 2'd1;
        end
      end else if (state_nxt.escape_active) begin
        if (state_nxt.raw_mode) begin
          state_nxt.escape_active = 1'b0;
          do_copy                 = 1'b1;
        end else if (b[7]) begin
          res             = push(res, 8'h00, sle_pkg::ST_ERROR);
          state_nxt.phase = PH_DONE;
        end else if (!state_nxt.letter_seen) begin
          state_nxt.escape_active = 1'b0;
          case (b) inside
            CH_BSLASH, CH_SQUOTE, CH_DQUOTE: res = push(res, b, sle_pkg::ST_DATA);
            CH_LC_A: res = push(res, CC_BEL, sle_pkg::ST_DATA);
            CH_LC_B: res = push(res, CC_BS, sle_pkg::ST_DATA);
            CH_LC_F: res = push(res, CC_FF, sle_pkg::ST_DATA);
            CH_LC_N: res = push(res, CC_LF, sle_pkg::ST_DATA);
            CH_LC_R: res = push(res, CC_CR, sle_pkg::ST_DATA);
            CH_LC_T: res = push(res, CC_TAB, sle_pkg::ST_DATA);
            CH_LC_V: res = push(res, CC_VT, sle_pkg::ST_DATA);
            CH_NL: begin
              // Line continuation: nothing is sent.
            end
            CH_LC_X, CH_LC_O: start_run = 1'b1;
            CH_LC_U, CH_UC_U: begin
              if (state_nxt.bytes_mode) begin
                res = push(push(res, CH_BSLASH, sle_pkg::ST_DATA), b, sle_pkg::ST_DATA);
              end else begin
                start_run = 1'b1;
              end
            end
            CH_UC_N: begin
              if (state_nxt.bytes_mode) begin
                res = push(push(res, CH_BSLASH, sle_pkg::ST_DATA), b, sle_pkg::ST_DATA);
              end else begin
                res             = push(res, 8'h00, sle_pkg::ST_ERROR);
                state_nxt.phase = PH_DONE;
              end
            end
            default: begin
              res = push(push(res, CH_BSLASH, sle_pkg::ST_DATA), b, sle_pkg::ST_DATA);
            end
          endcase
          if (start_run) begin
            state_nxt.escape_active = 1'b1;
            state_nxt.letter_seen   = 1'b1;
            state_nxt.escape_letter = b;
            state_nxt.digit_count   = 4'd0;
            state_nxt.hex_value     = 32'd0;
            state_nxt.octal_value   = 32'd0;
            state_nxt.octal_valid   = 1'b1;
          end
        end else begin
          if (state_nxt.escape_letter == CH_LC_U) begin
            limit = 4'd4;
          end else if (state_nxt.escape_letter == CH_UC_U) begin
            limit = 4'd8;
          end
          if (!d[4]) begin
            state_nxt.hex_value = {state_nxt.hex_value[27:0], d[3:0]};
            if (state_nxt.octal_valid && !d[3]) begin
              state_nxt.octal_value = {state_nxt.octal_value[28:0], d[2:0]};
            end else begin
              state_nxt.octal_valid = 1'b0;
            end
            state_nxt.digit_count = state_nxt.digit_count + 4'd1;
            if (state_nxt.digit_count >= limit) begin
              code = (state_nxt.escape_letter == CH_LC_O) ? state_nxt.octal_value
                                                          : state_nxt.hex_value;
              state_nxt.escape_active = 1'b0;
              state_nxt.letter_seen   = 1'b0;
              em  = emit_code(res, code, state_nxt.bytes_mode);
              res = em.list;
              if (em.bad) begin
                state_nxt.phase = PH_DONE;
              end
            end
          end else if (state_nxt.escape_letter == CH_LC_U ||
                       state_nxt.escape_letter == CH_UC_U) begin
            res             = push(res, 8'h00, sle_pkg::ST_ERROR);
            state_nxt.phase = PH_DONE;
          end else begin
            // The run ends here and this byte is then decoded normally.
            state_nxt.escape_active = 1'b0;
            state_nxt.letter_seen   = 1'b0;
            em  = emit_code(res, code, state_nxt.bytes_mode);
            res = em.list;
            if (em.bad) begin
              state_nxt.phase = PH_DONE;
            end else begin
              go_on = 1'b1;
            end
          end
        end
      end else begin
        go_on = 1'b1;
      end

      if (go_on) begin
        if (b == quote) begin
          res             = push(res, 8'h00, sle_pkg::ST_DONE);
          state_nxt.phase = PH_DONE;
        end else if (b == CH_BSLASH) begin
          if (state_nxt.raw_mode) begin
            res = push(res, CH_BSLASH, sle_pkg::ST_DATA);
          end
          state_nxt.escape_active = 1'b1;
          state_nxt.letter_seen   = 1'b0;
        end else begin
          do_copy = 1'b1;
        end
      end

      if (do_copy) begin
        if (lc[2]) begin
          res             = push(res, 8'h00, sle_pkg::ST_ERROR);
          state_nxt.phase = PH_DONE;
        end else begin
          if (b[7]) begin
            state_nxt.continuation_left = lc[1:0];
          end
          res = push(res, b, sle_pkg::ST_DATA);
        end
      end

      if (eot && state_nxt.phase == PH_BODY) begin
        if (state_nxt.continuation_left != 2'd0) begin
          res             = push(res, 8'h00, sle_pkg::ST_ERROR);
          state_nxt.phase = PH_DONE;
        end else begin
          if (state_nxt.escape_active && !state_nxt.raw_mode) begin
            if (!state_nxt.letter_seen || state_nxt.escape_letter == CH_LC_U ||
                state_nxt.escape_letter == CH_UC_U) begin
              res             = push(res, 8'h00, sle_pkg::ST_ERROR);
              state_nxt.phase = PH_DONE;
              stop            = 1'b1;
            end else begin
              code = (state_nxt.escape_letter == CH_LC_O) ? state_nxt.octal_value
                                                          : state_nxt.hex_value;
              state_nxt.escape_active = 1'b0;
              state_nxt.letter_seen   = 1'b0;
              em  = emit_code(res, code, state_nxt.bytes_mode);
              res = em.list;
              if (em.bad) begin
                state_nxt.phase = PH_DONE;
                stop            = 1'b1;
              end
            end
          end
          if (!stop) begin
            res             = push(res, 8'h00, sle_pkg::ST_DONE);
            state_nxt.phase = PH_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  assign list = res;

endmodule

@@ design/sle_result_queue.sv @@
`timescale 1ns / 1ps

module sle_result_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  sle_pkg::sle_list_t list,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output sle_pkg::sle_out_t  out_data
);

  localparam int unsigned ENT_W = $bits(sle_pkg::sle_entry_t);

  sle_pkg::sle_entry_t [sle_pkg::NRES_MAX-1:0] ent_r;
  sle_pkg::sle_cnt_t                           left_r;
  logic                                        pop;

  assign out_valid = (left_r != '0);
  assign pop       = out_valid && out_ready;

  // A new list may land when the queue drains in this very cycle.
  assign can_load = (left_r == '0) ||
                    (left_r == sle_pkg::sle_cnt_t'(1) && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (load) begin
      left_r <= list.cnt;
    end else if (pop) begin
      left_r <= left_r - sle_pkg::sle_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= list.ent;
    end else if (pop) begin
      ent_r <= ent_r >> ENT_W;
    end
  end

  assign out_data.out_byte = ent_r[0].value;
  assign out_data.status   = ent_r[0].status;
  assign out_data.run_end  = (left_r == sle_pkg::sle_cnt_t'(1));

endmodule

@@ design/string_literal_unescape.sv @@
// Latency: the first result beat of a byte is offered in the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte yields at most one beat and out_ready is high;
// a byte that yields more than one beat (up to six) holds off the next byte while the queue drains.
// Reset: synchronous, active low; the decoder returns to the prefix phase, queue empties.
`timescale 1ns / 1ps

module string_literal_unescape #(
  parameter int unsigned MAX_ESCAPE_DIGITS = sle_pkg::MAX_ESCAPE_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sle_pkg::sle_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sle_pkg::sle_out_t out_data
);

  // The decoder works out everything one input beat causes in a single pass:
  // the next literal state and the full, ordered list of result beats. The
  // state register updates on the accepting edge, so the following byte sees
  // it at once.
  //
  // The result queue doubles as the output register. It loads the whole list on
  // the accepting edge, shifts out one beat per cycle while out_ready is high and
  // takes input when it is empty or its last beat leaves in the same cycle, so
  // ordinary text flows one byte per cycle while out_ready is high. A byte with no
  // result (prefix letter, opening quote, non-raw escape) loads an empty list.

  logic               in_accept;
  sle_pkg::sle_list_t list;

  assign in_accept = in_valid && in_ready;

  sle_decode #(
    .MAX_ESCAPE_DIGITS(MAX_ESCAPE_DIGITS)
  ) u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_data),
    .list   (list)
  );

  sle_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .list      (list),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ design/sle_checker.sv @@
`timescale 1ns / 1ps
`include "string_literal_unescape_macros.svh"

module sle_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input sle_pkg::sle_out_t out_data
);

  // Only the three status codes ever appear.
  `SLE_ASSERT_NOW(a_status_code, out_valid, (out_data.status == sle_pkg::ST_DATA || out_data.status == sle_pkg::ST_DONE || out_data.status == sle_pkg::ST_ERROR))

  // Done and error beats carry a zero byte.
  `SLE_ASSERT_NOW(a_ctrl_zero, out_valid && out_data.status != sle_pkg::ST_DATA, out_data.out_byte == 8'h00)

  // Done and error always close the run of their input byte.
  `SLE_ASSERT_NOW(a_ctrl_last, out_valid && out_data.status != sle_pkg::ST_DATA, out_data.run_end)

  // A stalled result beat holds.
  `SLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind string_literal_unescape sle_checker u_sle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
